### sv/chda_pkg.sv
// Package with widths, codes and calendar helper functions for the date counter.
`default_nettype none

package chda_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned OrderW = 2;
  localparam int unsigned ModW   = 5;

  localparam logic [KindW-1:0] KindNextHour    = 3'd0;
  localparam logic [KindW-1:0] KindNextDay     = 3'd1;
  localparam logic [KindW-1:0] KindLoadDate    = 3'd2;
  localparam logic [KindW-1:0] KindCompareHour = 3'd3;
  localparam logic [KindW-1:0] KindCompareDay  = 3'd4;

  localparam logic [OrderW-1:0] OrderEqual   = 2'd0;
  localparam logic [OrderW-1:0] OrderEarlier = 2'd1;
  localparam logic [OrderW-1:0] OrderLater   = 2'd2;

  localparam logic [YearW-1:0]  YearMax    = 14'd9999;
  localparam logic [YearW-1:0]  YearReset  = 14'd2000;
  localparam logic [ModW-1:0]   YearMod25Reset = 5'd0;
  localparam logic [ModW-1:0]   Mod25Last  = 5'd24;
  localparam logic [MonthW-1:0] MonthJan   = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
  localparam logic [MonthW-1:0] MonthApr   = 4'd4;
  localparam logic [MonthW-1:0] MonthJun   = 4'd6;
  localparam logic [MonthW-1:0] MonthSep   = 4'd9;
  localparam logic [MonthW-1:0] MonthNov   = 4'd11;
  localparam logic [MonthW-1:0] MonthDec   = 4'd12;
  localparam logic [DayW-1:0]   DayFirst   = 5'd1;
  localparam logic [DayW-1:0]   Days28     = 5'd28;
  localparam logic [DayW-1:0]   Days29     = 5'd29;
  localparam logic [DayW-1:0]   Days30     = 5'd30;
  localparam logic [DayW-1:0]   Days31     = 5'd31;
  localparam logic [HourW-1:0]  HourFirst  = 5'd0;
  localparam logic [HourW-1:0]  HourLast   = 5'd23;

  // Residue modulo 25 by folding: 256 is 6 and 32 is 7 modulo 25.
  function automatic logic [ModW-1:0] mod25(input logic [YearW-1:0] y);
    logic [9:0] f1;
    logic [7:0] f2;
    f1 = 10'({y[13:8], 2'b00}) + 10'({y[13:8], 1'b0}) + 10'(y[7:0]);
    f2 = 8'({f1[9:5], 3'b000}) - 8'(f1[9:5]) + 8'(f1[4:0]);
    if (f2 >= 8'd100) f2 = f2 - 8'd100;
    if (f2 >= 8'd50)  f2 = f2 - 8'd50;
    if (f2 >= 8'd25)  f2 = f2 - 8'd25;
    return f2[ModW-1:0];
  endfunction

  // A year divisible by 400 is divisible by both 16 and 25.
  function automatic logic leap_of(input logic [YearW-1:0] y, input logic [ModW-1:0] r25);
    return (y[1:0] == 2'b00) && ((r25 != '0) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DayW-1:0] last_day(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] d;
    if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
      d = Days30;
    end else if (m == MonthFeb) begin
      d = leap ? Days29 : Days28;
    end else begin
      d = Days31;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### sv/chda_if.sv
// Handshake interfaces for the date counter's input and result channels.
`default_nettype none

interface chda_in_if;
  logic                          valid;
  logic                          ready;
  logic [chda_pkg::KindW-1:0]    kind;
  logic [chda_pkg::YearW-1:0]    date_year;
  logic [chda_pkg::MonthW-1:0]   date_month;
  logic [chda_pkg::DayW-1:0]     date_day;
  logic [chda_pkg::HourW-1:0]    date_hour;

  modport source (output valid, kind, date_year, date_month, date_day, date_hour,
                  input ready);
  modport sink (input valid, kind, date_year, date_month, date_day, date_hour,
                output ready);
endinterface

interface chda_out_if;
  logic                          valid;
  logic                          ready;
  logic [chda_pkg::YearW-1:0]    cur_year;
  logic [chda_pkg::MonthW-1:0]   cur_month;
  logic [chda_pkg::DayW-1:0]     cur_day;
  logic [chda_pkg::HourW-1:0]    cur_hour;
  logic                          is_leap;
  logic                          month_end;
  logic [chda_pkg::OrderW-1:0]   order;

  modport source (output valid, cur_year, cur_month, cur_day, cur_hour, is_leap,
                  month_end, order, input ready);
  modport sink (input valid, cur_year, cur_month, cur_day, cur_hour, is_leap,
                month_end, order, output ready);
endinterface

`default_nettype wire

### sv/calendar_hour_day_advance_top.sv
// Gregorian date counter with hour, day, load and compare operations.
//
//   channel | direction | word
//   in_i    | sink      | kind, date_year, date_month, date_day, date_hour
//   out_o   | source    | cur_year, cur_month, cur_day, cur_hour, is_leap, month_end, order
//
// Each word passes an input register and then a result register, from which its result is
// offered; a new word is taken every cycle unless both registers are full.
// The date state is updated as a word moves from the input register to the result register.
// Reset sets the date to January 1, 2000, hour 0, and empties both registers.
// A stalled result holds the input register; the input side stalls only when both are full.
`default_nettype none

module calendar_hour_day_advance_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  chda_in_if.sink   in_i,
  chda_out_if.source out_o
);

  logic                          s1_valid_q;
  logic [chda_pkg::KindW-1:0]    s1_kind_q;
  logic [chda_pkg::YearW-1:0]    s1_year_q;
  logic [chda_pkg::YearW-1:0]    s1_load_year_q;
  logic [chda_pkg::ModW-1:0]     s1_load_r25_q;
  logic [chda_pkg::MonthW-1:0]   s1_month_q;
  logic [chda_pkg::DayW-1:0]     s1_day_q;
  logic [chda_pkg::HourW-1:0]    s1_hour_q;

  logic [chda_pkg::YearW-1:0]    year_q, year_d;
  logic [chda_pkg::ModW-1:0]     r25_q, r25_d;
  logic [chda_pkg::MonthW-1:0]   month_q, month_d;
  logic [chda_pkg::DayW-1:0]     day_q, day_d;
  logic [chda_pkg::HourW-1:0]    hour_q, hour_d;

  logic                          out_valid_q;
  logic [chda_pkg::YearW-1:0]    out_year_q;
  logic [chda_pkg::MonthW-1:0]   out_month_q;
  logic [chda_pkg::DayW-1:0]     out_day_q;
  logic [chda_pkg::HourW-1:0]    out_hour_q;
  logic                          out_leap_q;
  logic                          out_end_q;
  logic [chda_pkg::OrderW-1:0]   out_order_q, order_d;

  logic                          s2_take;
  logic                          in_take;
  logic [chda_pkg::YearW-1:0]    load_year;
  logic                          leap_cur;
  logic                          leap_d;
  logic                          day_roll;
  logic [chda_pkg::YearW-1:0]    adv_year;
  logic [chda_pkg::ModW-1:0]     adv_r25;
  logic [chda_pkg::MonthW-1:0]   adv_month;
  logic [chda_pkg::DayW-1:0]     adv_day;

  assign s2_take  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s2_take;
  assign in_take  = in_i.valid && in_i.ready;

  assign load_year = (in_i.date_year > chda_pkg::YearMax) ? chda_pkg::YearMax : in_i.date_year;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s2_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q      <= in_i.kind;
      s1_year_q      <= in_i.date_year;
      s1_load_year_q <= load_year;
      s1_load_r25_q  <= chda_pkg::mod25(load_year);
      s1_month_q     <= in_i.date_month;
      s1_day_q       <= in_i.date_day;
      s1_hour_q      <= in_i.date_hour;
    end
  end

  assign leap_cur = chda_pkg::leap_of(year_q, r25_q);
  assign day_roll = day_q >= chda_pkg::last_day(month_q, leap_cur);

  always_comb begin
    adv_year  = year_q;
    adv_r25   = r25_q;
    adv_month = month_q;
    adv_day   = day_q + 1'b1;
    if (day_roll) begin
      adv_day = chda_pkg::DayFirst;
      if (month_q == chda_pkg::MonthDec) begin
        adv_month = chda_pkg::MonthJan;
        if (year_q < chda_pkg::YearMax) begin
          adv_year = year_q + 1'b1;
          adv_r25  = (r25_q == chda_pkg::Mod25Last) ? '0 : r25_q + 1'b1;
        end
      end else begin
        adv_month = month_q + 1'b1;
      end
    end
  end

  always_comb begin
    year_d  = year_q;
    r25_d   = r25_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    order_d = chda_pkg::OrderEqual;
    unique case (s1_kind_q)
      chda_pkg::KindNextHour: begin
        if (hour_q >= chda_pkg::HourLast) begin
          year_d  = adv_year;
          r25_d   = adv_r25;
          month_d = adv_month;
          day_d   = adv_day;
          hour_d  = chda_pkg::HourFirst;
        end else begin
          hour_d = hour_q + 1'b1;
        end
      end
      chda_pkg::KindNextDay: begin
        year_d  = adv_year;
        r25_d   = adv_r25;
        month_d = adv_month;
        day_d   = adv_day;
        hour_d  = chda_pkg::HourFirst;
      end
      chda_pkg::KindLoadDate: begin
        year_d  = s1_load_year_q;
        r25_d   = s1_load_r25_q;
        month_d = s1_month_q;
        day_d   = s1_day_q;
        hour_d  = s1_hour_q;
      end
      chda_pkg::KindCompareHour, chda_pkg::KindCompareDay: begin
        priority if (year_q != s1_year_q) begin
          order_d = (year_q < s1_year_q) ? chda_pkg::OrderEarlier : chda_pkg::OrderLater;
        end else if (month_q != s1_month_q) begin
          order_d = (month_q < s1_month_q) ? chda_pkg::OrderEarlier : chda_pkg::OrderLater;
        end else if (day_q != s1_day_q) begin
          order_d = (day_q < s1_day_q) ? chda_pkg::OrderEarlier : chda_pkg::OrderLater;
        end else if (s1_kind_q == chda_pkg::KindCompareHour && hour_q != s1_hour_q) begin
          order_d = (hour_q < s1_hour_q) ? chda_pkg::OrderEarlier : chda_pkg::OrderLater;
        end else begin
          order_d = chda_pkg::OrderEqual;
        end
      end
      default: begin
        order_d = chda_pkg::OrderEqual;
      end
    endcase
  end

  assign leap_d = chda_pkg::leap_of(year_d, r25_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= chda_pkg::YearReset;
      r25_q   <= chda_pkg::YearMod25Reset;
      month_q <= chda_pkg::MonthJan;
      day_q   <= chda_pkg::DayFirst;
      hour_q  <= chda_pkg::HourFirst;
    end else if (s2_take) begin
      year_q  <= year_d;
      r25_q   <= r25_d;
      month_q <= month_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take) begin
      out_year_q  <= year_d;
      out_month_q <= month_d;
      out_day_q   <= day_d;
      out_hour_q  <= hour_d;
      out_leap_q  <= leap_d;
      out_end_q   <= day_d >= chda_pkg::last_day(month_d, leap_d);
      out_order_q <= order_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cur_year  = out_year_q;
  assign out_o.cur_month = out_month_q;
  assign out_o.cur_day   = out_day_q;
  assign out_o.cur_hour  = out_hour_q;
  assign out_o.is_leap   = out_leap_q;
  assign out_o.month_end = out_end_q;
  assign out_o.order     = out_order_q;

endmodule

`default_nettype wire

### dv/chda_date_checker.sv
// Checker that predicts the date counter's result words and compares them with the DUT.
`timescale 1ns / 100ps

module chda_date_checker
  import chda_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  chda_in_if          in_mon,
  chda_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
  } cal_date_t;

  typedef struct packed {
    cal_date_t         date;
    logic              leap;
    logic              month_end;
    logic [OrderW-1:0] order;
  } date_report_t;

  cal_date_t    stored_date;
  date_report_t report_q[$];

  function automatic logic leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [DayW-1:0] days_in_month(input cal_date_t dt);
    logic [DayW-1:0] len;
    case (dt.month)
      MonthApr, MonthJun, MonthSep, MonthNov: len = Days30;
      MonthFeb: len = leap_year(dt.year) ? Days29 : Days28;
      default: len = Days31;
    endcase
    return len;
  endfunction

  function automatic cal_date_t next_day(input cal_date_t dt);
    dt.hour = HourFirst;
    if (dt.day >= days_in_month(dt)) begin
      dt.day = DayFirst;
      if (dt.month == MonthDec) begin
        dt.month = MonthJan;
        if (dt.year < YearMax) dt.year = dt.year + 1'b1;
      end else begin
        dt.month = dt.month + 1'b1;
      end
    end else begin
      dt.day = dt.day + 1'b1;
    end
    return dt;
  endfunction

  function automatic cal_date_t apply_word(input cal_date_t dt, input logic [KindW-1:0] kind,
                                           input cal_date_t given);
    case (kind)
      KindNextHour: begin
        if (dt.hour >= HourLast) dt = next_day(dt);
        else dt.hour = dt.hour + 1'b1;
      end
      KindNextDay: dt = next_day(dt);
      KindLoadDate: begin
        dt = given;
        if (given.year > YearMax) dt.year = YearMax;
      end
      default: ;
    endcase
    return dt;
  endfunction

  function automatic logic [OrderW-1:0] field_order(input int unsigned a, input int unsigned b);
    if (a == b) return OrderEqual;
    return (a < b) ? OrderEarlier : OrderLater;
  endfunction

  function automatic logic [OrderW-1:0] date_order(input cal_date_t s, input cal_date_t g,
                                                   input logic [KindW-1:0] kind);
    logic [OrderW-1:0] ord;
    ord = OrderEqual;
    if (kind == KindCompareHour || kind == KindCompareDay) begin
      ord = field_order(s.year, g.year);
      if (ord == OrderEqual) ord = field_order(s.month, g.month);
      if (ord == OrderEqual) ord = field_order(s.day, g.day);
      if (ord == OrderEqual && kind == KindCompareHour) ord = field_order(s.hour, g.hour);
    end
    return ord;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    date_report_t expected;
    cal_date_t    given;
    if (!rst_ni) begin
      stored_date  = '{YearReset, MonthJan, DayFirst, HourFirst};
      report_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (report_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count_o++;
        end else begin
          expected = report_q.pop_front();
          check_field("cur_year", 16'(expected.date.year), 16'(out_mon.cur_year));
          check_field("cur_month", 16'(expected.date.month), 16'(out_mon.cur_month));
          check_field("cur_day", 16'(expected.date.day), 16'(out_mon.cur_day));
          check_field("cur_hour", 16'(expected.date.hour), 16'(out_mon.cur_hour));
          check_field("is_leap", 16'(expected.leap), 16'(out_mon.is_leap));
          check_field("month_end", 16'(expected.month_end), 16'(out_mon.month_end));
          check_field("order", 16'(expected.order), 16'(out_mon.order));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        given = '{in_mon.date_year, in_mon.date_month, in_mon.date_day, in_mon.date_hour};
        expected.order     = date_order(stored_date, given, in_mon.kind);
        stored_date        = apply_word(stored_date, in_mon.kind, given);
        expected.date      = stored_date;
        expected.leap      = leap_year(stored_date.year);
        expected.month_end = stored_date.day >= days_in_month(stored_date);
        report_q.push_back(expected);
      end
      pending_o = report_q.size();
    end
  end

endmodule

### dv/tb_calendar_hour_day_advance_top.sv
// Testbench top that drives the date counter with directed and random words and gives the verdict.
`timescale 1ns / 100ps

module tb_calendar_hour_day_advance_top;
  import chda_pkg::*;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
  } stim_date_t;

  localparam logic [KindW-1:0] KindSpareFirst = 3'd5;
  localparam logic [KindW-1:0] KindSpareMid   = 3'd6;
  localparam logic [KindW-1:0] KindSpareLast  = 3'd7;
  localparam int unsigned      QuietLimit     = 5000;
  localparam int unsigned      HoldCycles     = 300;

  logic        clk;
  logic        rst_n;
  int unsigned hold_requests;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned words_sent;
  int unsigned quiet_cycles;
  int unsigned idle_in_pct;
  int unsigned idle_out_pct;

  chda_in_if  in_ch();
  chda_out_if out_ch();

  calendar_hour_day_advance_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  chda_date_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL calendar_hour_day_advance_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= idle_out_pct);
      end
    end
  end

  task automatic send_word(input logic [KindW-1:0] kind, input stim_date_t dt);
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.date_year  <= dt.year;
    in_ch.date_month <= dt.month;
    in_ch.date_day   <= dt.day;
    in_ch.date_hour  <= dt.hour;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  function automatic stim_date_t pick_date();
    stim_date_t dt;
    case ($urandom_range(0, 4))
      0: dt.year = YearW'($urandom_range(0, 9999));
      1: dt.year = YearMax - YearW'($urandom_range(0, 1));
      2: dt.year = YearW'($urandom_range(0, 99) * 100);
      3: dt.year = YearW'($urandom_range(1, 2499) * 4);
      default: dt.year = YearW'($urandom_range(1990, 2110));
    endcase
    dt.month = ($urandom_range(0, 3) == 0) ? MonthDec : MonthW'($urandom_range(1, 12));
    dt.day   = ($urandom_range(0, 1) == 0) ? DayW'($urandom_range(27, 31))
                                           : DayW'($urandom_range(1, 28));
    dt.hour  = ($urandom_range(0, 1) == 0) ? HourW'($urandom_range(20, 23))
                                           : HourW'($urandom_range(0, 23));
    return dt;
  endfunction

  function automatic stim_date_t perturb(input stim_date_t dt);
    case ($urandom_range(0, 8))
      0: dt.year  = dt.year + 1'b1;
      1: dt.year  = dt.year - 1'b1;
      2: dt.month = dt.month + 1'b1;
      3: dt.month = dt.month - 1'b1;
      4: dt.day   = dt.day + 1'b1;
      5: dt.day   = dt.day - 1'b1;
      6: dt.hour  = dt.hour + 1'b1;
      7: dt.hour  = dt.hour - 1'b1;
      default: ;
    endcase
    return dt;
  endfunction

  function automatic logic [KindW-1:0] pick_compare();
    return ($urandom_range(0, 1) == 0) ? KindCompareHour : KindCompareDay;
  endfunction

  task automatic send_noise_word();
    stim_date_t dt;
    dt.year  = YearW'($urandom_range(0, 16383));
    dt.month = MonthW'($urandom_range(0, 15));
    dt.day   = DayW'($urandom_range(0, 31));
    dt.hour  = HourW'($urandom_range(0, 31));
    send_word(KindW'($urandom_range(0, 7)), dt);
  endtask

  task automatic run_calendar_sequence();
    stim_date_t  base;
    int unsigned roll;
    base = pick_date();
    send_word(KindLoadDate, base);
    if ($urandom_range(0, 1) == 0) send_word(pick_compare(), perturb(base));
    repeat ($urandom_range(1, 40)) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) send_word(KindNextHour, pick_date());
      else if (roll < 90) send_word(KindNextDay, pick_date());
      else send_word(pick_compare(), perturb(base));
    end
    send_word(pick_compare(), perturb(base));
  endtask

  task automatic run_phase(input int unsigned target);
    while (words_sent < target) begin
      if ($urandom_range(0, 99) < 12) send_noise_word();
      else run_calendar_sequence();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    hold_requests    = 0;
    words_sent       = 0;
    idle_in_pct      = 15;
    idle_out_pct     = 71;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KindNextHour;
    in_ch.date_year  = '0;
    in_ch.date_month = '0;
    in_ch.date_day   = '0;
    in_ch.date_hour  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_word(KindCompareHour, '{14'd2000, 4'd1, 5'd1, 5'd0});
    send_word(KindNextHour, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindLoadDate, '{14'd9999, 4'd12, 5'd31, 5'd23});
    send_word(KindNextHour, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindLoadDate, '{14'd16383, 4'd15, 5'd31, 5'd31});
    send_word(KindNextHour, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindNextDay, '{14'd16383, 4'd15, 5'd31, 5'd31});
    send_word(KindLoadDate, '{14'd1900, 4'd2, 5'd28, 5'd5});
    send_word(KindNextDay, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindLoadDate, '{14'd2000, 4'd2, 5'd28, 5'd12});
    send_word(KindNextDay, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindNextDay, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindLoadDate, '{14'd2100, 4'd2, 5'd29, 5'd0});
    send_word(KindNextDay, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindLoadDate, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindNextDay, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindSpareFirst, pick_date());
    send_word(KindSpareMid, pick_date());
    send_word(KindSpareLast, pick_date());
    send_word(KindCompareHour, '{14'd0, 4'd0, 5'd1, 5'd1});
    send_word(KindCompareDay, '{14'd0, 4'd0, 5'd1, 5'd31});
    send_word(KindCompareHour, '{14'd1, 4'd0, 5'd1, 5'd0});
    send_word(KindCompareDay, '{14'd0, 4'd0, 5'd0, 5'd0});
    send_word(KindLoadDate, '{14'd2024, 4'd4, 5'd30, 5'd23});
    send_word(KindNextHour, '{14'd0, 4'd0, 5'd0, 5'd0});

    run_phase(350);
    drain_results();

    idle_in_pct  = 71;
    idle_out_pct = 15;
    run_phase(700);
    drain_results();

    idle_in_pct  = 0;
    idle_out_pct = 0;
    hold_requests++;
    run_phase(1050);
    drain_results();
    repeat (8) @(negedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS calendar_hour_day_advance_top");
    end else begin
      $display("FAIL calendar_hour_day_advance_top");
    end
    $finish;
  end

endmodule
